FILE: sv/bpmt_pkg.sv
// ----------------------------------------------------------------------------
// Breakpoint match table package
// Shared widths, operation and status codes, and the control word that the
// controller broadcasts along the row of cells.
// ----------------------------------------------------------------------------
package bpmt_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 16;
   localparam int ADDR_W              = 64;
   localparam int MODE_W              = 2;
   localparam int STATUS_W            = 2;
   localparam int SLOT_W              = 4;

   localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CHECK = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   // Control word seen by every cell in the same cycle
   typedef struct packed {
      logic              push_scan;   // token looks for disabled slots, moving up
      logic              advance;     // token moves one cell on
      logic              clear;       // scan finished, drop the token
      logic              kill;        // check commit: one-shot hit disables itself
      logic [ADDR_W-1:0] key;         // address to match, or to store on a write
      logic              wr_oneshot;
      logic              wr_disabled;
   } cell_bcast_type;

endpackage

FILE: sv/bpmt_cell.sv
// ----------------------------------------------------------------------------
// Breakpoint match table cell
// Holds one entry and one position of the scan token. The token arrives from
// the cell below on a push scan and from the cell above on a check scan.
// ----------------------------------------------------------------------------
module bpmt_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  bpmt_pkg::cell_bcast_type bc,
   input  logic                    seed,
   input  logic                    wr_en,
   input  logic                    tok_below,
   input  logic                    tok_above,
   output logic                    tok,
   output logic                    hit,
   output logic                    hit_oneshot
);

   logic                        tok_ff, tok_in;
   logic [bpmt_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic                        oneshot_ff, oneshot_in;
   logic                        disabled_ff, disabled_in;
   logic                        flag;

   always_comb begin
      if (bc.push_scan) begin
         flag = disabled_ff;
      end else begin
         flag = !disabled_ff && (addr_ff == bc.key);
      end
   end

   assign tok         = tok_ff;
   assign hit         = tok_ff & flag;
   assign hit_oneshot = hit & oneshot_ff;

   always_comb begin
      tok_in      = tok_ff;
      addr_in     = addr_ff;
      oneshot_in  = oneshot_ff;
      disabled_in = disabled_ff;
      priority if (bc.clear) begin
         tok_in = 1'b0;
      end else if (seed) begin
         tok_in = 1'b1;
      end else if (bc.advance) begin
         tok_in = bc.push_scan ? tok_below : tok_above;
      end
      if (wr_en) begin
         addr_in     = bc.key;
         oneshot_in  = bc.wr_oneshot;
         disabled_in = bc.wr_disabled;
      end else if (bc.kill && hit_oneshot) begin
         disabled_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
      addr_ff     <= addr_in;
      oneshot_ff  <= oneshot_in;
      disabled_ff <= disabled_in;
   end

endmodule

FILE: sv/breakpoint_match_table.sv
// ----------------------------------------------------------------------------
// Breakpoint match table
// Row of entry cells with a scan token passed cell to cell, one per cycle while the result side is free.
// ----------------------------------------------------------------------------
// Pop, unused codes, and push or check on an empty table: the result is registered
// straight from the request, with no scan.
// Other push and check: the token visits one cell at a time (check from the top
// live entry down, push from slot 0 up), result registered after the last one;
// no new item is taken until the scan has ended.
// Reset clears the live count, the token and the controller; entries need none.
module breakpoint_match_table #(
   parameter int TABLE_DEPTH = bpmt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bpmt_pkg::MODE_W-1:0]   req_mode,
   input  logic [bpmt_pkg::ADDR_W-1:0]   req_addr,
   input  logic                          req_oneshot,
   input  logic                          req_start_disabled,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bpmt_pkg::STATUS_W-1:0] rsp_status,
   output logic [bpmt_pkg::SLOT_W-1:0]   rsp_slot
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   typedef enum logic {ST_IDLE, ST_SCAN} state_type;

   state_type                      state_ff, state_in;
   logic [bpmt_pkg::MODE_W-1:0]    mode_ff, mode_in;
   logic [bpmt_pkg::ADDR_W-1:0]    addr_ff, addr_in;
   logic                           oneshot_ff, oneshot_in;
   logic                           dis_ff, dis_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [bpmt_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [bpmt_pkg::SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;

   bpmt_pkg::cell_bcast_type       bc;
   logic                           accept, out_free;
   logic                           seed_en, wr_go;
   logic [IDX_W-1:0]               seed_idx, wr_idx, last_idx, count_idx;
   logic [TABLE_DEPTH-1:0]         tok_vec, hit_vec, os_vec;
   logic                           any_hit, any_os;

   function automatic logic [bpmt_pkg::SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] i);
      logic [IDX_W+bpmt_pkg::SLOT_W-1:0] ext;
      ext = {{bpmt_pkg::SLOT_W{1'b0}}, i};
      return ext[bpmt_pkg::SLOT_W-1:0];
   endfunction

   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept     = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;

   assign any_hit   = |hit_vec;
   assign any_os    = |os_vec;
   assign last_idx  = IDX_W'(count_ff - 1'b1);
   assign count_idx = IDX_W'(count_ff);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      addr_in       = addr_ff;
      oneshot_in    = oneshot_ff;
      dis_in        = dis_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      seed_en       = 1'b0;
      seed_idx      = '0;
      wr_go         = 1'b0;
      wr_idx        = idx_ff;

      bc.push_scan   = (mode_ff == bpmt_pkg::MODE_PUSH);
      bc.advance     = 1'b0;
      bc.clear       = 1'b0;
      bc.kill        = 1'b0;
      bc.key         = (state_ff == ST_IDLE) ? req_addr : addr_ff;
      bc.wr_oneshot  = (state_ff == ST_IDLE) ? req_oneshot : oneshot_ff;
      bc.wr_disabled = (state_ff == ST_IDLE) ? req_start_disabled : dis_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in    = req_mode;
               addr_in    = req_addr;
               oneshot_in = req_oneshot;
               dis_in     = req_start_disabled;
               unique case (req_mode)
                  bpmt_pkg::MODE_PUSH: begin
                     if (count_ff == '0) begin
                        // empty table: append straight away at slot 0
                        wr_go         = 1'b1;
                        wr_idx        = '0;
                        count_in      = CNT_W'(1);
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = bpmt_pkg::STATUS_OK;
                        rsp_slot_in   = '0;
                     end else begin
                        seed_en  = 1'b1;
                        seed_idx = '0;
                        idx_in   = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  bpmt_pkg::MODE_POP: begin
                     if (count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                     end
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = bpmt_pkg::STATUS_OK;
                     rsp_slot_in   = '0;
                  end
                  bpmt_pkg::MODE_CHECK: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = bpmt_pkg::STATUS_MISS;
                        rsp_slot_in   = '0;
                     end else begin
                        seed_en  = 1'b1;
                        seed_idx = last_idx;
                        idx_in   = last_idx;
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = bpmt_pkg::STATUS_MISS;
                     rsp_slot_in   = '0;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (out_free) begin
               priority if (any_hit) begin
                  bc.clear      = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = bpmt_pkg::STATUS_OK;
                  rsp_slot_in   = slot_of(idx_ff);
                  state_in      = ST_IDLE;
                  if (bc.push_scan) begin
                     wr_go = 1'b1;
                  end else begin
                     bc.kill = 1'b1;
                     // one-shot hit on the top entry shrinks the table
                     if (any_os && idx_ff == last_idx) begin
                        count_in = count_ff - 1'b1;
                     end
                  end
               end else if (bc.push_scan && idx_ff == last_idx) begin
                  bc.clear     = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
                  if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                     rsp_status_in = bpmt_pkg::STATUS_FULL;
                     rsp_slot_in   = '0;
                  end else begin
                     wr_go         = 1'b1;
                     wr_idx        = count_idx;
                     count_in      = count_ff + 1'b1;
                     rsp_status_in = bpmt_pkg::STATUS_OK;
                     rsp_slot_in   = slot_of(count_idx);
                  end
               end else if (!bc.push_scan && idx_ff == '0) begin
                  bc.clear      = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = bpmt_pkg::STATUS_MISS;
                  rsp_slot_in   = '0;
                  state_in      = ST_IDLE;
               end else begin
                  bc.advance = 1'b1;
                  idx_in     = bc.push_scan ? idx_ff + 1'b1 : idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      addr_ff       <= addr_in;
      oneshot_ff    <= oneshot_in;
      dis_ff        <= dis_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic tok_below, tok_above;
      if (i == 0) begin : g_bot
         assign tok_below = 1'b0;
      end else begin : g_mid_lo
         assign tok_below = tok_vec[i-1];
      end
      if (i == TABLE_DEPTH - 1) begin : g_top
         assign tok_above = 1'b0;
      end else begin : g_mid_hi
         assign tok_above = tok_vec[i+1];
      end
      bpmt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .bc          (bc),
         .seed        (seed_en && (seed_idx == IDX_W'(i))),
         .wr_en       (wr_go && (wr_idx == IDX_W'(i))),
         .tok_below   (tok_below),
         .tok_above   (tok_above),
         .tok         (tok_vec[i]),
         .hit         (hit_vec[i]),
         .hit_oneshot (os_vec[i])
      );
   end

endmodule

FILE: bench/tb_breakpoint_match_table.sv
// ----------------------------------------------------------------------------
// Breakpoint match table testbench
// Drives push, pop, check and unused-code items through the request channel.
// A behavioural copy of the table predicts each result as its item is taken.
// The results channel is checked in order. Both sides idle at random, apart
// from one long steady stretch.
// ----------------------------------------------------------------------------
module tb_breakpoint_match_table;

   localparam int BP_DEPTH = bpmt_pkg::TABLE_DEPTH_DEFAULT;
   localparam logic [bpmt_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int POOL_SIZE  = 8;
   localparam int DRAIN_WAIT = 40;

   typedef struct packed {
      logic [bpmt_pkg::STATUS_W-1:0] status;
      logic [bpmt_pkg::SLOT_W-1:0]   slot;
   } bp_result_type;

   logic                          clock              = 1'b0;
   logic                          reset              = 1'b1;
   logic                          req_valid          = 1'b0;
   logic                          req_stall;
   logic [bpmt_pkg::MODE_W-1:0]   req_mode           = bpmt_pkg::MODE_POP;
   logic [bpmt_pkg::ADDR_W-1:0]   req_addr           = '0;
   logic                          req_oneshot        = 1'b0;
   logic                          req_start_disabled = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall          = 1'b0;
   logic [bpmt_pkg::STATUS_W-1:0] rsp_status;
   logic [bpmt_pkg::SLOT_W-1:0]   rsp_slot;

   // Shadow copy of the table
   logic [bpmt_pkg::ADDR_W-1:0] shadow_addr[BP_DEPTH];
   logic                        shadow_oneshot[BP_DEPTH];
   logic                        shadow_disabled[BP_DEPTH];
   int                          shadow_live;

   bp_result_type               pending_results[$];
   bp_result_type               head_result;
   int                          mismatch_count = 0;
   bit                          steady_flow    = 1'b0;
   logic [bpmt_pkg::ADDR_W-1:0] addr_pool[POOL_SIZE];

   breakpoint_match_table #(.TABLE_DEPTH(BP_DEPTH)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_addr           (req_addr),
      .req_oneshot        (req_oneshot),
      .req_start_disabled (req_start_disabled),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_slot           (rsp_slot)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit take_gap();
      return !steady_flow && ($urandom_range(0, 99) < 31);
   endfunction

   function automatic logic [bpmt_pkg::ADDR_W-1:0] rand_addr();
      return {$urandom, $urandom};
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   // Applies one item to the shadow table and returns the result it causes
   function automatic bp_result_type table_step(input logic [bpmt_pkg::MODE_W-1:0] mode,
                                                input logic [bpmt_pkg::ADDR_W-1:0] addr,
                                                input logic oneshot,
                                                input logic start_disabled);
      bp_result_type res;
      int            target;
      bit            found;
      res.status = bpmt_pkg::STATUS_MISS;
      res.slot   = '0;
      found      = 1'b0;
      case (mode)
         bpmt_pkg::MODE_PUSH: begin
            target = shadow_live;
            for (int k = 0; k < shadow_live; k++) begin
               if (!found && shadow_disabled[k]) begin
                  target = k;
                  found  = 1'b1;
               end
            end
            if (target >= BP_DEPTH) begin
               res.status = bpmt_pkg::STATUS_FULL;
            end else begin
               shadow_addr[target]     = addr;
               shadow_oneshot[target]  = oneshot;
               shadow_disabled[target] = start_disabled;
               if (target == shadow_live)
                  shadow_live++;
               res.status = bpmt_pkg::STATUS_OK;
               res.slot   = target[bpmt_pkg::SLOT_W-1:0];
            end
         end
         bpmt_pkg::MODE_POP: begin
            if (shadow_live > 0)
               shadow_live--;
            res.status = bpmt_pkg::STATUS_OK;
         end
         bpmt_pkg::MODE_CHECK: begin
            for (int k = shadow_live - 1; k >= 0; k--) begin
               if (!found && !shadow_disabled[k] && shadow_addr[k] == addr) begin
                  found = 1'b1;
                  if (shadow_oneshot[k]) begin
                     shadow_disabled[k] = 1'b1;
                     if (k + 1 == shadow_live)
                        shadow_live--;
                  end
                  res.status = bpmt_pkg::STATUS_OK;
                  res.slot   = k[bpmt_pkg::SLOT_W-1:0];
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // Valid is left high after acceptance so back-to-back items need not drop valid in between.
   // The stall is looked at on the falling edge, where it has settled.
   task automatic send_item(input logic [bpmt_pkg::MODE_W-1:0] mode,
                            input logic [bpmt_pkg::ADDR_W-1:0] addr,
                            input logic oneshot, input logic start_disabled);
      while (take_gap()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_mode           <= mode;
      req_addr           <= addr;
      req_oneshot        <= oneshot;
      req_start_disabled <= start_disabled;
      @(negedge clock);
      while (req_stall)
         @(negedge clock);
      @(posedge clock);
      pending_results.push_back(table_step(mode, addr, oneshot, start_disabled));
   endtask

   // Result-side stall
   always @(posedge clock) begin
      rsp_stall <= take_gap();
   end

   // Results checker: an item seen here is taken at the next rising edge
   always @(negedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected item: status %0d slot %0d", rsp_status, rsp_slot);
            mismatch_count++;
         end else begin
            head_result = pending_results.pop_front();
            if (rsp_status !== head_result.status) begin
               $error("status: expected %0d, got %0d", head_result.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_slot !== head_result.slot) begin
               $error("slot: expected %0d, got %0d", head_result.slot, rsp_slot);
               mismatch_count++;
            end
         end
      end
   end

   task automatic test_corner_cases();
      send_item(bpmt_pkg::MODE_POP, '1, 1'b1, 1'b1);                 // pop on empty
      send_item(bpmt_pkg::MODE_CHECK, '0, 1'b0, 1'b0);               // check on empty
      send_item(MODE_UNUSED, '1, 1'b1, 1'b1);
      send_item(bpmt_pkg::MODE_PUSH, '0, 1'b0, 1'b0);
      send_item(bpmt_pkg::MODE_PUSH, '1, 1'b1, 1'b0);
      send_item(bpmt_pkg::MODE_PUSH, 64'h8000_0000_0000_0000, 1'b0, 1'b1);
      send_item(bpmt_pkg::MODE_CHECK, '1, 1'b0, 1'b0);               // one-shot hit below top
      send_item(bpmt_pkg::MODE_CHECK, '1, 1'b1, 1'b1);               // now disabled: miss
      send_item(bpmt_pkg::MODE_CHECK, 64'h8000_0000_0000_0000, 1'b0, 1'b0);
      // reuses a disabled slot
      send_item(bpmt_pkg::MODE_PUSH, 64'h5555_5555_5555_5555, 1'b0, 1'b0);
      send_item(bpmt_pkg::MODE_PUSH, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0);
      // one-shot hit on top
      send_item(bpmt_pkg::MODE_CHECK, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0);
      send_item(bpmt_pkg::MODE_PUSH, '0, 1'b0, 1'b0);
      send_item(bpmt_pkg::MODE_CHECK, '0, 1'b0, 1'b0);               // duplicate: highest wins
      send_item(bpmt_pkg::MODE_POP, '0, 1'b0, 1'b0);
      send_item(bpmt_pkg::MODE_CHECK, '0, 1'b1, 1'b0);
      send_item(MODE_UNUSED, '0, 1'b0, 1'b0);
      send_item(bpmt_pkg::MODE_CHECK, 64'h0000_0000_0000_0001, 1'b0, 1'b0);
      for (int i = 0; i < 4; i++)
         send_item(bpmt_pkg::MODE_POP, rand_addr(), 1'b0, 1'b0);
   endtask

   task automatic test_fill_and_drain();
      logic [bpmt_pkg::ADDR_W-1:0] addr;
      while (shadow_live < BP_DEPTH) begin
         addr = rand_addr();
         addr_pool[$urandom_range(0, POOL_SIZE - 1)] = addr;
         send_item(bpmt_pkg::MODE_PUSH, addr, rand_bit(), 1'b0);
      end
      send_item(bpmt_pkg::MODE_PUSH, rand_addr(), 1'b0, 1'b0);       // full table
      send_item(bpmt_pkg::MODE_PUSH, '1, 1'b1, 1'b1);
      for (int i = 0; i < 8; i++)
         send_item(bpmt_pkg::MODE_CHECK, addr_pool[$urandom_range(0, POOL_SIZE - 1)],
                   1'b0, 1'b0);
      while (shadow_live > 0)
         send_item(bpmt_pkg::MODE_POP, rand_addr(), rand_bit(), rand_bit());
      send_item(bpmt_pkg::MODE_POP, rand_addr(), 1'b0, 1'b0);
   endtask

   // Phases alternate between filling and draining so the table sweeps empty to full
   task automatic test_random_traffic(input int n_items);
      int                          r;
      int                          push_w;
      int                          pop_w;
      logic [bpmt_pkg::MODE_W-1:0] mode;
      logic [bpmt_pkg::ADDR_W-1:0] addr;
      for (int i = 0; i < n_items; i++) begin
         steady_flow = (i >= n_items / 3) && (i < n_items / 3 + 200);
         if ((i / 60) % 2 == 0) begin
            push_w = 45;
            pop_w  = 10;
         end else begin
            push_w = 15;
            pop_w  = 40;
         end
         r = $urandom_range(0, 99);
         if (r < push_w)
            mode = bpmt_pkg::MODE_PUSH;
         else if (r < push_w + pop_w)
            mode = bpmt_pkg::MODE_POP;
         else if (r < 95)
            mode = bpmt_pkg::MODE_CHECK;
         else
            mode = MODE_UNUSED;
         if ($urandom_range(0, 3) == 0) begin
            addr = rand_addr();
            if (mode == bpmt_pkg::MODE_PUSH)
               addr_pool[$urandom_range(0, POOL_SIZE - 1)] = addr;
         end else begin
            addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
         end
         send_item(mode, addr, rand_bit(), $urandom_range(0, 4) == 0);
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      shadow_live = 0;
      for (int i = 0; i < POOL_SIZE; i++)
         addr_pool[i] = rand_addr();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_cases();
      test_fill_and_drain();
      test_random_traffic(1040);
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

FILE: breakpoint_match_table.f
sv/bpmt_pkg.sv
sv/bpmt_cell.sv
sv/breakpoint_match_table.sv
bench/tb_breakpoint_match_table.sv
